/* design/vlnc_pkg.sv */
package vlnc_pkg;

   localparam int DATA_W   = 32;
   localparam int MAXL_W   = 31;
   localparam int SCALAR_W = 33;
   localparam int SUM_W    = 64;
   localparam int NUM_W    = 64;
   localparam int ROOT_W   = 33;
   localparam int QUOT_W   = 32;

   localparam logic [1:0] OP_LEN    = 2'd0;
   localparam logic [1:0] OP_LENSQ  = 2'd1;
   localparam logic [1:0] OP_NORM   = 2'd2;
   localparam logic [1:0] OP_CLAMP  = 2'd3;

   localparam logic [SCALAR_W-1:0] SCALAR_MAX = '1;

   // per-item sideband carried through the root and divide pipelines
   typedef struct packed {
      logic [1:0]                   op;
      logic [2:0][DATA_W-1:0]       vec;
      logic [2:0][NUM_W-1:0]        num;
      logic [MAXL_W-1:0]            max_len;
      logic [SCALAR_W-1:0]          sq;
      logic                         sat;
      logic [ROOT_W-1:0]            root;
   } item_type;

endpackage

/* design/vlnc_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module vlnc_sqrt
   import vlnc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [SUM_W-1:0] in_sum,
   input  item_type         in_item,
   output logic             out_valid,
   output item_type         out_item
);

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 3;

   logic [RAD_W-1:0]  rad_ff   [ROOT_W];
   logic [REM_W-1:0]  rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   item_type          item_ff  [ROOT_W];
   logic              valid_ff [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic [RAD_W-1:0]  cur_rad;
      logic [REM_W-1:0]  cur_rem;
      logic [ROOT_W-1:0] cur_root;
      item_type          cur_item;
      logic              cur_valid;
      logic [REM_W-1:0]  rem_shift;
      logic [REM_W-1:0]  trial;
      logic              take;

      if (s == 0) begin : g_first
         assign cur_rad   = {{(RAD_W-SUM_W){1'b0}}, in_sum};
         assign cur_rem   = '0;
         assign cur_root  = '0;
         assign cur_item  = in_item;
         assign cur_valid = in_valid;
      end else begin : g_next
         assign cur_rad   = rad_ff[s-1];
         assign cur_rem   = rem_ff[s-1];
         assign cur_root  = root_ff[s-1];
         assign cur_item  = item_ff[s-1];
         assign cur_valid = valid_ff[s-1];
      end

      // bring down two radicand bits and try the next root bit
      assign rem_shift = {cur_rem[REM_W-3:0], cur_rad[RAD_W-1 -: 2]};
      assign trial     = {{(REM_W-ROOT_W-2){1'b0}}, cur_root, 2'b01};
      assign take      = (rem_shift >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= {cur_rad[RAD_W-3:0], 2'b00};
            rem_ff[s]  <= take ? (rem_shift - trial) : rem_shift;
            root_ff[s] <= {cur_root[ROOT_W-2:0], take};
            item_ff[s] <= cur_item;
         end
      end
   end

   always_comb begin
      out_item      = item_ff[ROOT_W-1];
      out_item.root = root_ff[ROOT_W-1];
   end
   assign out_valid = valid_ff[ROOT_W-1];

endmodule

/* design/vlnc_div.sv */
// Three pipelined restoring dividers sharing the root as divisor.
// The quotient is known to fit 32 bits, so the high numerator word seeds
// the remainder and one quotient bit is formed per stage.
module vlnc_div
   import vlnc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  item_type                in_item,
   output logic                    out_valid,
   output item_type                out_item,
   output logic [2:0][QUOT_W-1:0]  out_quot
);

   localparam int REM_W = ROOT_W + 1;
   localparam int LO_W  = NUM_W - QUOT_W;

   logic [2:0][REM_W-1:0]  rem_ff   [QUOT_W];
   logic [2:0][LO_W-1:0]   lo_ff    [QUOT_W];
   logic [2:0][QUOT_W-1:0] quot_ff  [QUOT_W];
   item_type               item_ff  [QUOT_W];
   logic                   valid_ff [QUOT_W];

   for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
      logic [2:0][REM_W-1:0]  cur_rem;
      logic [2:0][LO_W-1:0]   cur_lo;
      logic [2:0][QUOT_W-1:0] cur_quot;
      item_type               cur_item;
      logic                   cur_valid;
      logic [REM_W-1:0]       divisor;

      if (s == 0) begin : g_first
         for (genvar c = 0; c < 3; c++) begin : g_seed
            assign cur_rem[c] = {{(REM_W-(NUM_W-LO_W)){1'b0}}, in_item.num[c][NUM_W-1:LO_W]};
            assign cur_lo[c]  = in_item.num[c][LO_W-1:0];
         end
         assign cur_quot  = '0;
         assign cur_item  = in_item;
         assign cur_valid = in_valid;
      end else begin : g_next
         assign cur_rem   = rem_ff[s-1];
         assign cur_lo    = lo_ff[s-1];
         assign cur_quot  = quot_ff[s-1];
         assign cur_item  = item_ff[s-1];
         assign cur_valid = valid_ff[s-1];
      end

      assign divisor = {1'b0, cur_item.root};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= cur_valid;
         end
      end

      // shift in the next numerator bit and subtract where it fits
      for (genvar c = 0; c < 3; c++) begin : g_lane
         logic [REM_W-1:0] trial;
         logic             take;

         assign trial = {cur_rem[c][REM_W-2:0], cur_lo[c][LO_W-1]};
         assign take  = (trial >= divisor);

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s][c]  <= take ? (trial - divisor) : trial;
               lo_ff[s][c]   <= {cur_lo[c][LO_W-2:0], 1'b0};
               quot_ff[s][c] <= {cur_quot[c][QUOT_W-2:0], take};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            item_ff[s] <= cur_item;
         end
      end
   end

   assign out_valid = valid_ff[QUOT_W-1];
   assign out_item  = item_ff[QUOT_W-1];
   assign out_quot  = quot_ff[QUOT_W-1];

endmodule

/* design/vector3_length_normalize_clamp.sv */
// Fixed-point 3-vector unit (signed Q16.16 by default): length, length squared
// (saturating), normalize and clamp-length. One item is accepted every cycle
// while the result side is not stalled; each result passes through 2 front
// stages for squares and products, 33 square-root stages, 32 divide stages
// and 1 output register. Throughput is set by the fully pipelined root and
// dividers; a stall on the result side holds the whole pipeline in place.
module vector3_length_normalize_clamp
   import vlnc_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // vec_x, vec_y, vec_z, max_len, zero pad
   input  logic [1:0]   req_tuser,  // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,  // res_x, res_y, res_z, scalar, zero pad
   output logic [1:0]   rsp_tuser   // zero_len, saturated
);

   logic en;

   // stage A: magnitudes and squares
   logic                    a_valid_ff;
   logic [1:0]              a_op_ff;
   logic [2:0][DATA_W-1:0]  a_vec_ff;
   logic [MAXL_W-1:0]       a_max_ff;
   logic [2:0][DATA_W-1:0]  a_mag_ff;
   logic [2:0][SUM_W-1:0]   a_sqr_ff;

   // stage B: sum, numerators, length squared
   logic                    b_valid_ff;
   logic [SUM_W-1:0]        b_sum_ff;
   item_type                b_item_ff;
   item_type                b_item_in;
   logic [SUM_W-1:0]        b_sum_in;

   logic                    s_valid;
   item_type                s_item;
   logic                    d_valid;
   item_type                d_item;
   logic [2:0][QUOT_W-1:0]  d_quot;

   logic                    out_valid_ff;
   logic [135:0]            out_data_ff;
   logic [1:0]              out_user_ff;
   logic [135:0]            out_data_in;
   logic [1:0]              out_user_in;

   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff   <= req_tvalid;
         b_valid_ff   <= a_valid_ff;
         out_valid_ff <= d_valid;
      end
   end

   // take magnitudes and square each component
   for (genvar c = 0; c < 3; c++) begin : g_front
      logic [DATA_W-1:0] comp;
      logic [DATA_W-1:0] mag;

      assign comp = req_tdata[c*DATA_W +: DATA_W];
      assign mag  = comp[DATA_W-1] ? (~comp + 1'b1) : comp;

      always_ff @(posedge clock) begin
         if (en) begin
            a_vec_ff[c] <= comp;
            a_mag_ff[c] <= mag;
            a_sqr_ff[c] <= {{(SUM_W-DATA_W){1'b0}}, mag} * {{(SUM_W-DATA_W){1'b0}}, mag};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_op_ff  <= req_tuser;
         a_max_ff <= req_tdata[3*DATA_W +: MAXL_W];
      end
   end

   // form the sum, the divider numerators and the saturated length squared
   always_comb begin
      logic [SUM_W-1:0] shifted;

      b_sum_in        = a_sqr_ff[0] + a_sqr_ff[1] + a_sqr_ff[2];
      shifted         = b_sum_in >> FRAC_BITS;
      b_item_in       = '0;
      b_item_in.op    = a_op_ff;
      b_item_in.vec   = a_vec_ff;
      b_item_in.max_len = a_max_ff;
      if (shifted > {{(SUM_W-SCALAR_W){1'b0}}, SCALAR_MAX}) begin
         b_item_in.sq  = SCALAR_MAX;
         b_item_in.sat = 1'b1;
      end else begin
         b_item_in.sq  = shifted[SCALAR_W-1:0];
         b_item_in.sat = 1'b0;
      end
      for (int c = 0; c < 3; c++) begin
         if (a_op_ff == OP_CLAMP) begin
            b_item_in.num[c] = {{(NUM_W-DATA_W){1'b0}}, a_mag_ff[c]}
                             * {{(NUM_W-MAXL_W){1'b0}}, a_max_ff};
         end else begin
            b_item_in.num[c] = {{(NUM_W-DATA_W){1'b0}}, a_mag_ff[c]} << FRAC_BITS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_sum_ff  <= b_sum_in;
         b_item_ff <= b_item_in;
      end
   end

   vlnc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_valid_ff),
      .in_sum    (b_sum_ff),
      .in_item   (b_item_ff),
      .out_valid (s_valid),
      .out_item  (s_item)
   );

   vlnc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_item   (s_item),
      .out_valid (d_valid),
      .out_item  (d_item),
      .out_quot  (d_quot)
   );

   // pick the result for the op
   always_comb begin
      logic [2:0][DATA_W-1:0] res;
      logic [2:0][DATA_W-1:0] scaled;
      logic [SCALAR_W-1:0]    scalar;
      logic                   zero_len;
      logic                   sat;

      for (int c = 0; c < 3; c++) begin
         scaled[c] = d_item.vec[c][DATA_W-1] ? (~d_quot[c] + 1'b1) : d_quot[c];
      end
      res      = d_item.vec;
      scalar   = d_item.root;
      zero_len = 1'b0;
      sat      = 1'b0;
      unique case (d_item.op)
         OP_LEN: begin
         end
         OP_LENSQ: begin
            scalar = d_item.sq;
            sat    = d_item.sat;
         end
         OP_NORM: begin
            if (d_item.root == '0) begin
               res      = '0;
               zero_len = 1'b1;
            end else begin
               res = scaled;
            end
         end
         OP_CLAMP: begin
            if (d_item.root >= {{(ROOT_W-MAXL_W){1'b0}}, d_item.max_len}) begin
               if (d_item.root == '0) begin
                  res      = '0;
                  zero_len = 1'b1;
               end else begin
                  res = scaled;
               end
            end
         end
         default: begin
         end
      endcase
      out_data_in = {{(136-3*DATA_W-SCALAR_W){1'b0}}, scalar, res[2], res[1], res[0]};
      out_user_in = {sat, zero_len};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   // a zero-length result carries a zero vector
   a_zero_vec: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[3*DATA_W-1:0] == '0)
      else $error("zero_len with nonzero vector");

   // saturation pins the scalar at full scale
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[3*DATA_W +: SCALAR_W] == SCALAR_MAX)
      else $error("saturated without full-scale scalar");

   // the two flags come from different ops
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("zero_len and saturated together");

   // a stall freezes the front of the pipeline
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(a_valid_ff) && $stable(b_valid_ff))
      else $error("pipeline moved during stall");

endmodule
